FILE: src/binary_to_roman_numeral_top_macros.svh
// ----------------------------------------------------------------------------
// binary to roman numeral - assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_ROMAN_NUMERAL_TOP_MACROS_SVH
`define BINARY_TO_ROMAN_NUMERAL_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define RBN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define RBN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rbn_pkg.sv
// ----------------------------------------------------------------------------
// rbn_pkg
// shared types, constants and numeral tables for the roman numeral converter
// ----------------------------------------------------------------------------
`default_nettype none

package rbn_pkg;

   localparam int VALUE_W   = 13;
   localparam int SYMBOL_W  = 8;
   localparam int POS_W     = 4;
   localparam int DIGIT_W   = 4;
   localparam int REM_W     = 12;
   localparam int ROMAN_MAX = 3999;
   localparam int DIV_THOU  = 1000;
   localparam int DIV_HUND  = 100;
   localparam int DIV_TEN   = 10;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [SYMBOL_W-1:0] ZERO_CHAR = 8'h4E;
   localparam logic [SYMBOL_W-1:0] ERR_CHAR  = 8'h00;

   // decimal levels, most significant first
   localparam logic [1:0] LVL_THOU = 2'd0;
   localparam logic [1:0] LVL_HUND = 2'd1;
   localparam logic [1:0] LVL_TEN  = 2'd2;
   localparam logic [1:0] LVL_ONE  = 2'd3;

   typedef logic [3:0][DIGIT_W-1:0] digits_type;

   typedef struct packed {
      logic       err;
      logic       zero;
      digits_type digits;
   } rbn_entry_type;

   typedef struct packed {
      logic       found;
      logic [1:0] lvl;
   } lvl_sel_type;

   typedef enum logic [1:0] {
      CODE_END,
      CODE_UNIT,
      CODE_FIVE,
      CODE_TEN
   } pat_code_type;

   // symbol by index: M D C L X V I
   function automatic logic [SYMBOL_W-1:0] roman_sym(input logic [2:0] idx);
      logic [SYMBOL_W-1:0] s;
      unique case (idx)
         3'd0:    s = 8'h4D;
         3'd1:    s = 8'h44;
         3'd2:    s = 8'h43;
         3'd3:    s = 8'h4C;
         3'd4:    s = 8'h58;
         3'd5:    s = 8'h56;
         3'd6:    s = 8'h49;
         default: s = ERR_CHAR;
      endcase
      return s;
   endfunction

   // symbol pattern of one decimal digit, first symbol in element 0
   function automatic pat_code_type pat_code(input logic [DIGIT_W-1:0] d,
                                             input logic [1:0] j);
      logic [3:0][1:0] p;
      unique case (d)
         4'd1:    p = {CODE_END,  CODE_END,  CODE_END,  CODE_UNIT};
         4'd2:    p = {CODE_END,  CODE_END,  CODE_UNIT, CODE_UNIT};
         4'd3:    p = {CODE_END,  CODE_UNIT, CODE_UNIT, CODE_UNIT};
         4'd4:    p = {CODE_END,  CODE_END,  CODE_FIVE, CODE_UNIT};
         4'd5:    p = {CODE_END,  CODE_END,  CODE_END,  CODE_FIVE};
         4'd6:    p = {CODE_END,  CODE_END,  CODE_UNIT, CODE_FIVE};
         4'd7:    p = {CODE_END,  CODE_UNIT, CODE_UNIT, CODE_FIVE};
         4'd8:    p = {CODE_UNIT, CODE_UNIT, CODE_UNIT, CODE_FIVE};
         4'd9:    p = {CODE_END,  CODE_END,  CODE_TEN,  CODE_UNIT};
         default: p = {CODE_END,  CODE_END,  CODE_END,  CODE_END};
      endcase
      return pat_code_type'(p[j]);
   endfunction

   // number of symbols written for one decimal digit
   function automatic logic [2:0] pat_len(input logic [DIGIT_W-1:0] d);
      logic [2:0] n;
      unique case (d)
         4'd1, 4'd5:             n = 3'd1;
         4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
         4'd3, 4'd7:             n = 3'd3;
         4'd8:                   n = 3'd4;
         default:                n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: src/binary_to_roman_numeral_top.sv
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_top
// converts a signed value to its roman numeral, one ascii character per
// response, with a digit-splitting front, a small queue and a character back
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_value
//   rsp      out        rsp_valid / rsp_stall  rsp_symbol rsp_position
//                                              rsp_last rsp_out_of_range
//
// the front accepts a request, runs 3 digit steps for a value in range and
// none for zero or an error, then pushes the entry into the queue
// the back sends one character per cycle while not stalled, up to 15 for one
// request, with a gap between runs while it loads the next queue entry
// synchronous reset empties the queue and the response register; no sweep
// a stalled response holds, and the queue lets the front keep converting
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_roman_numeral_top import rbn_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SYMBOL_W-1:0]       rsp_symbol,
   output logic [POS_W-1:0]          rsp_position,
   output logic                      rsp_last,
   output logic                      rsp_out_of_range
);

   localparam int ENTRY_W = $bits(rbn_entry_type);

   logic               push_valid;
   logic               push_full;
   rbn_entry_type      push_entry;
   logic               pop_req;
   logic               pop_empty;
   logic [ENTRY_W-1:0] pop_data;

   rbn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_entry (push_entry)
   );

   rbn_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_entry),
      .pop_req    (pop_req),
      .pop_empty  (pop_empty),
      .pop_data   (pop_data)
   );

   rbn_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_req          (pop_req),
      .pop_empty        (pop_empty),
      .pop_entry        (rbn_entry_type'(pop_data)),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol       (rsp_symbol),
      .rsp_position     (rsp_position),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

`default_nettype wire

FILE: src/rbn_front.sv
// ----------------------------------------------------------------------------
// rbn_front
// takes a request, flags error or zero, and otherwise splits the value into
// decimal digits one level per cycle before handing it to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module rbn_front import rbn_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      push_valid,
   input  logic                      push_full,
   output rbn_entry_type             push_entry
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_CONV,
      F_PUSH
   } front_state_type;

   front_state_type      state_ff;
   logic                 err_ff;
   logic                 zero_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [1:0]           lvl_ff;
   digits_type           digits_ff;

   logic                 req_err;
   logic                 req_zero;
   logic [13:0]          thr [1:9];
   logic [DIGIT_W-1:0]   digit;
   logic [REM_W-1:0]     sub;
   logic [REM_W-1:0]     rem_in;

   assign req_err  = req_value[VALUE_W-1] ||
                     (req_value[REM_W-1:0] > REM_W'(ROMAN_MAX));
   assign req_zero = (req_value == '0);

   // digit thresholds of the current level
   always_comb begin
      for (int k = 1; k < 10; k++) begin
         unique case (lvl_ff)
            LVL_THOU: thr[k] = 14'(k * DIV_THOU);
            LVL_HUND: thr[k] = 14'(k * DIV_HUND);
            default:  thr[k] = 14'(k * DIV_TEN);
         endcase
      end
   end

   always_comb begin
      digit = '0;
      sub   = '0;
      for (int k = 1; k < 10; k++) begin
         if ({2'b00, rem_ff} >= thr[k]) begin
            digit = DIGIT_W'(k);
            sub   = thr[k][REM_W-1:0];
         end
      end
      rem_in = rem_ff - sub;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  err_ff   <= req_err;
                  zero_ff  <= req_zero;
                  rem_ff   <= req_value[REM_W-1:0];
                  lvl_ff   <= LVL_THOU;
                  state_ff <= (req_err || req_zero) ? F_PUSH : F_CONV;
               end
            end
            F_CONV: begin
               digits_ff[lvl_ff] <= digit;
               rem_ff            <= rem_in;
               if (lvl_ff == LVL_TEN) begin
                  digits_ff[LVL_ONE] <= rem_in[DIGIT_W-1:0];
                  state_ff           <= F_PUSH;
               end else begin
                  lvl_ff <= lvl_ff + 2'd1;
               end
            end
            F_PUSH: begin
               if (!push_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

   assign req_stall         = (state_ff != F_IDLE);
   assign push_valid        = (state_ff == F_PUSH);
   assign push_entry.err    = err_ff;
   assign push_entry.zero   = zero_ff;
   assign push_entry.digits = digits_ff;

endmodule

`default_nettype wire

FILE: src/rbn_queue.sv
// ----------------------------------------------------------------------------
// rbn_queue
// small first-in first-out buffer between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module rbn_queue #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_full,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop_req,
   output logic             pop_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_full = (count_ff == CNT_W'(DEPTH));
   assign pop_empty = (count_ff == '0);
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_req && !pop_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/rbn_back.sv
// ----------------------------------------------------------------------------
// rbn_back
// walks the decimal digits of one queued entry and emits one numeral
// character per cycle into the response register while it is not stalled
// ----------------------------------------------------------------------------
`default_nettype none

module rbn_back import rbn_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   output logic                pop_req,
   input  logic                pop_empty,
   input  rbn_entry_type       pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SYMBOL_W-1:0] rsp_symbol,
   output logic [POS_W-1:0]    rsp_position,
   output logic                rsp_last,
   output logic                rsp_out_of_range
);

   logic                busy_ff;
   rbn_entry_type       ent_ff;
   logic [1:0]          lvl_ff;
   logic [1:0]          step_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                rsp_valid_ff;
   logic [SYMBOL_W-1:0] rsp_symbol_ff;
   logic [POS_W-1:0]    rsp_position_ff;
   logic                rsp_last_ff;
   logic                rsp_oor_ff;

   logic                out_free;
   logic                emit;
   logic [DIGIT_W-1:0]  cur_digit;
   pat_code_type        code;
   logic [2:0]          unit_idx;
   logic [2:0]          sym_idx;
   logic [SYMBOL_W-1:0] sym;
   logic                more;
   lvl_sel_type         start_sel;
   lvl_sel_type         lower_sel;

   // first nonzero digit at or below the given level
   function automatic lvl_sel_type find_nz(input digits_type dg, input logic [2:0] from);
      lvl_sel_type r;
      r.found = 1'b0;
      r.lvl   = LVL_THOU;
      for (int i = 3; i >= 0; i--) begin
         if (dg[i] != '0 && 3'(i) >= from) begin
            r.found = 1'b1;
            r.lvl   = 2'(i);
         end
      end
      return r;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   assign pop_req   = !busy_ff && !pop_empty;
   assign start_sel = find_nz(pop_entry.digits, 3'd0);
   assign lower_sel = find_nz(ent_ff.digits, {1'b0, lvl_ff} + 3'd1);
   assign cur_digit = ent_ff.digits[lvl_ff];
   assign code      = pat_code(cur_digit, step_ff);
   assign unit_idx  = {lvl_ff, 1'b0};
   assign more      = ({1'b0, step_ff} + 3'd1) < pat_len(cur_digit);
   assign sym       = roman_sym(sym_idx);

   always_comb begin
      unique case (code)
         CODE_FIVE: sym_idx = unit_idx - 3'd1;
         CODE_TEN:  sym_idx = unit_idx - 3'd2;
         default:   sym_idx = unit_idx;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop_req) begin
            busy_ff <= 1'b1;
            ent_ff  <= pop_entry;
            lvl_ff  <= start_sel.lvl;
            step_ff <= '0;
            pos_ff  <= '0;
         end
         if (emit) begin
            rsp_valid_ff    <= 1'b1;
            rsp_position_ff <= pos_ff;
            priority if (ent_ff.err) begin
               rsp_symbol_ff <= ERR_CHAR;
               rsp_last_ff   <= 1'b1;
               rsp_oor_ff    <= 1'b1;
               busy_ff       <= 1'b0;
            end else if (ent_ff.zero) begin
               rsp_symbol_ff <= ZERO_CHAR;
               rsp_last_ff   <= 1'b1;
               rsp_oor_ff    <= 1'b0;
               busy_ff       <= 1'b0;
            end else begin
               rsp_symbol_ff <= sym;
               rsp_last_ff   <= !more && !lower_sel.found;
               rsp_oor_ff    <= 1'b0;
               pos_ff        <= pos_ff + 1'b1;
               if (more) begin
                  step_ff <= step_ff + 2'd1;
               end else if (lower_sel.found) begin
                  lvl_ff  <= lower_sel.lvl;
                  step_ff <= '0;
               end else begin
                  busy_ff <= 1'b0;
               end
            end
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol       = rsp_symbol_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

`default_nettype wire

FILE: src/rbn_checker.sv
// ----------------------------------------------------------------------------
// rbn_checker
// port-level checks on the response stream of the converter
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_to_roman_numeral_top_macros.svh"

module rbn_checker import rbn_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [SYMBOL_W-1:0]       rsp_symbol,
   input wire logic [POS_W-1:0]          rsp_position,
   input wire logic                      rsp_last,
   input wire logic                      rsp_out_of_range
);

   `RBN_ASSERT_NOW(a_err_alone, rsp_valid && rsp_out_of_range, rsp_last && rsp_symbol == ERR_CHAR && rsp_position == '0, "error response must be a lone marked result")

   `RBN_ASSERT_NOW(a_zero_alone, rsp_valid && rsp_symbol == ZERO_CHAR, rsp_last && rsp_position == '0 && !rsp_out_of_range, "zero response must be a lone marked result")

   `RBN_ASSERT_NEXT(a_run_steps, rsp_valid && !rsp_stall && !rsp_last, rsp_valid && !rsp_out_of_range && rsp_position == $past(rsp_position) + 4'd1, "run must continue with the next position")

   `RBN_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_symbol) && $stable(rsp_position) && $stable(rsp_last), "stalled response changed")

endmodule

bind binary_to_roman_numeral_top rbn_checker u_checker (.*);

`default_nettype wire

FILE: verif/binary_to_roman_numeral_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_top_tb
// drives signed values into the converter and checks every numeral character
// that comes back against a behavioral speller, in order, field by field;
// a directed table first, then random values under changing idle patterns,
// one long response hold-off and one drain pause
// ----------------------------------------------------------------------------

module binary_to_roman_numeral_top_tb;
   import rbn_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT_REQ  = 60;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 40;
   localparam int PHASE_ITEMS  = 146;
   localparam int PAUSE_AT     = 300;
   localparam int TABLE_ROWS   = 23;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic [POS_W-1:0]    position;
      logic                last;
      logic                out_of_range;
   } numeral_char_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      typed;
      logic [SYMBOL_W-1:0]       symbol;
      logic                      out_of_range;
   } value_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [SYMBOL_W-1:0]       rsp_symbol;
   logic [POS_W-1:0]          rsp_position;
   logic                      rsp_last;
   logic                      rsp_out_of_range;

   numeral_char_type awaited_chars [$];
   int               mismatches = 0;
   int               req_idle_pct = 0;
   int               rsp_stall_pct = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;
   int               reqs_seen = 0;

   value_row_type value_table [TABLE_ROWS] = '{
      '{13'sd0,     1'b1, ZERO_CHAR, 1'b0},
      '{-13'sd1,    1'b1, ERR_CHAR,  1'b1},
      '{-13'sd4096, 1'b1, ERR_CHAR,  1'b1},
      '{13'sd4095,  1'b1, ERR_CHAR,  1'b1},
      '{13'sd4000,  1'b1, ERR_CHAR,  1'b1},
      '{-13'sd2048, 1'b1, ERR_CHAR,  1'b1},
      '{13'sd3999,  1'b0, ERR_CHAR,  1'b0},
      '{13'sd3888,  1'b0, ERR_CHAR,  1'b0},
      '{13'sd1,     1'b0, ERR_CHAR,  1'b0},
      '{13'sd4,     1'b0, ERR_CHAR,  1'b0},
      '{13'sd5,     1'b0, ERR_CHAR,  1'b0},
      '{13'sd9,     1'b0, ERR_CHAR,  1'b0},
      '{13'sd10,    1'b0, ERR_CHAR,  1'b0},
      '{13'sd40,    1'b0, ERR_CHAR,  1'b0},
      '{13'sd50,    1'b0, ERR_CHAR,  1'b0},
      '{13'sd90,    1'b0, ERR_CHAR,  1'b0},
      '{13'sd100,   1'b0, ERR_CHAR,  1'b0},
      '{13'sd400,   1'b0, ERR_CHAR,  1'b0},
      '{13'sd500,   1'b0, ERR_CHAR,  1'b0},
      '{13'sd900,   1'b0, ERR_CHAR,  1'b0},
      '{13'sd1000,  1'b0, ERR_CHAR,  1'b0},
      '{13'sd1994,  1'b0, ERR_CHAR,  1'b0},
      '{13'sd2048,  1'b0, ERR_CHAR,  1'b0}
   };

   binary_to_roman_numeral_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol       (rsp_symbol),
      .rsp_position     (rsp_position),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [SYMBOL_W-1:0] glyph_at(input int idx);
      case (idx)
         0:       return "M";
         1:       return "D";
         2:       return "C";
         3:       return "L";
         4:       return "X";
         5:       return "V";
         6:       return "I";
         default: return ERR_CHAR;
      endcase
   endfunction

   task automatic spell_numeral(input logic signed [VALUE_W-1:0] v);
      logic [SYMBOL_W-1:0] run [$];
      int rest;
      int div;
      int digit;
      int lvl;
      if (v < 0 || v > ROMAN_MAX) begin
         awaited_chars.push_back('{ERR_CHAR, 4'd0, 1'b1, 1'b1});
         return;
      end
      if (v == 0) begin
         awaited_chars.push_back('{ZERO_CHAR, 4'd0, 1'b1, 1'b0});
         return;
      end
      rest = int'(v);
      div = DIV_THOU;
      for (lvl = 0; lvl < 4; lvl++) begin
         digit = rest / div;
         rest = rest % div;
         div = div / 10;
         if (digit == 9) begin
            run.push_back(glyph_at(2 * lvl));
            run.push_back(glyph_at(2 * lvl - 2));
         end else if (digit == 4) begin
            run.push_back(glyph_at(2 * lvl));
            run.push_back(glyph_at(2 * lvl - 1));
         end else begin
            if (digit >= 5) run.push_back(glyph_at(2 * lvl - 1));
            repeat (digit % 5) run.push_back(glyph_at(2 * lvl));
         end
      end
      foreach (run[k]) begin
         awaited_chars.push_back('{run[k], POS_W'(k), (k == run.size() - 1), 1'b0});
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 60) return VALUE_W'($urandom_range(ROMAN_MAX));
      if (r < 80) return VALUE_W'($urandom_range(3) * 1000 + $urandom_range(9) * 100 +
                                  $urandom_range(9) * 10 + $urandom_range(9));
      if (r < 90) return VALUE_W'($urandom);
      if (r < 95) return VALUE_W'($urandom_range(4095, 4000));
      return -VALUE_W'($urandom_range(4096, 1));
   endfunction

   task automatic offer_value(input logic signed [VALUE_W-1:0] v);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         req_value <= VALUE_W'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // response side stall, with one long hold-off once HOLD_AT_REQ requests have been accepted
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) reqs_seen <= reqs_seen + 1;
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (!hold_done && reqs_seen == HOLD_AT_REQ) begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      numeral_char_type got;
      numeral_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_symbol, rsp_position, rsp_last, rsp_out_of_range};
         if (awaited_chars.size() == 0) begin
            $display("%0t: unexpected response sym=%h pos=%0d last=%b oor=%b", $time,
                     got.symbol, got.position, got.last, got.out_of_range);
            mismatches++;
         end else begin
            want = awaited_chars.pop_front();
            if (got !== want) begin
               $display("%0t: expected sym=%h pos=%0d last=%b oor=%b, got sym=%h pos=%0d last=%b oor=%b",
                        $time, want.symbol, want.position, want.last, want.out_of_range,
                        got.symbol, got.position, got.last, got.out_of_range);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: watchdog expired", $time);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int missing;
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 14;
      rsp_stall_pct = 75;
      foreach (value_table[i]) begin
         offer_value(value_table[i].value);
         if (value_table[i].typed) begin
            awaited_chars.push_back('{value_table[i].symbol, 4'd0, 1'b1,
                                      value_table[i].out_of_range});
         end else begin
            spell_numeral(value_table[i].value);
         end
      end

      n = 0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 14;
               rsp_stall_pct = 75;
            end
            1: begin
               req_idle_pct = 75;
               rsp_stall_pct = 14;
            end
            default: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         repeat (PHASE_ITEMS) begin
            logic signed [VALUE_W-1:0] v;
            if (n == PAUSE_AT) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (awaited_chars.size() != 0) @(posedge clock);
            end
            v = pick_value();
            offer_value(v);
            spell_numeral(v);
            n++;
         end
      end
      req_valid <= 1'b0;

      while (awaited_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      missing = awaited_chars.size();
      if (missing != 0) $display("%0t: %0d expected characters never arrived", $time, missing);
      if (mismatches == 0 && missing == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/rbn_pkg.sv
src/rbn_front.sv
src/rbn_queue.sv
src/rbn_back.sv
src/binary_to_roman_numeral_top.sv
src/rbn_checker.sv
verif/binary_to_roman_numeral_top_tb.sv
